[sv/hfc_pkg.sv]
// Package for the phone-number hit counter.
// Shared constants and types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hfc_pkg;
    localparam int TableSize = 2039;
    localparam int CountBits = 20;
    localparam int PhoneBits = 44;
    localparam int SlotBits = $clog2(TableSize);
    localparam int TieBits = 11;
    localparam int KeyBits = 16;

    typedef logic [PhoneBits-1:0] phone_t;
    typedef logic [CountBits-1:0] count_t;
    typedef logic [SlotBits-1:0] slot_t;
    typedef logic [TieBits-1:0] tie_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic clr_write;
        logic load;
        logic hash;
        logic rd;
        logic step;
        logic commit;
        logic full;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic found;
        logic exhausted;
    } status_t;
endpackage
`default_nettype wire

[sv/hfc_ctrl.sv]
// Controller for the phone-number hit counter.
// Sequences clear, hash, probe and update. Depends on hfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hfc_ctrl
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire             out_stall,
    output hfc_pkg::cmd_t   cmd,
    input  hfc_pkg::status_t sts
);
    import hfc_pkg::*;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_valid_next = out_valid_reg && out_stall;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                cmd.hash = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.found)
                    state_next = ST_UPDATE;
                else if (sts.exhausted)
                begin
                    cmd.full = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.step = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_UPDATE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

[sv/hfc_dp.sv]
// Datapath for the phone-number hit counter.
// Slot memory, probe address unit, leader tracking. Depends on hfc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hfc_dp
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire [43:0]               phone_bcd,
    input  hfc_pkg::cmd_t            cmd,
    output hfc_pkg::status_t         sts,
    output logic [43:0]              leader_bcd,
    output logic [19:0]              leader_count,
    output logic [10:0]              tie_total,
    output logic                     was_new,
    output logic                     table_full
);
    import hfc_pkg::*;

    localparam int TieMax = (1 << TieBits) - 1;
    localparam count_t CountMax = '1;
    localparam logic [SlotBits:0] SizeW = (SlotBits + 1)'(TableSize);
    localparam int FoldMul = (1 << SlotBits) % TableSize;

    logic   vmem [TableSize];
    phone_t nmem [TableSize];
    count_t cmem [TableSize];

    slot_t  clr_reg;
    phone_t num_reg;
    logic [KeyBits-1:0] key_reg;
    slot_t  pos_reg, home_reg;
    slot_t  off_reg;
    slot_t  odd_reg;
    logic   minus_reg;
    logic [SlotBits:0] j_reg;
    logic   v_rd;
    phone_t n_rd;
    count_t c_rd;
    phone_t best_num_reg;
    count_t best_cnt_reg;
    tie_t   best_ties_reg;
    logic   new_reg, full_reg;
    phone_t o_num_reg;
    count_t o_cnt_reg;
    tie_t   o_ties_reg;
    logic   o_new_reg, o_full_reg;

    logic [SlotBits:0] sum_w, dif_w, pos_next, r_sq_next;
    logic [SlotBits:0] fold_w, home_w, odd_w;
    count_t cnew;
    logic   changed;

    function automatic logic [3:0] dig(input phone_t n, input int p);
        dig = n[(10 - p) * 4 +: 4];
    endfunction

    assign sts.clr_done = (clr_reg == slot_t'(TableSize - 1));
    assign sts.found = !v_rd || (n_rd == num_reg);
    assign sts.exhausted = (j_reg == SizeW - 1'b1);

    // off_reg holds r^2 mod size; odd_reg holds 2r+1 mod size
    always_comb
    begin
        sum_w = {1'b0, off_reg} + {1'b0, odd_reg};
        r_sq_next = (sum_w >= SizeW) ? sum_w - SizeW : sum_w;
        if (!minus_reg)
            sum_w = {1'b0, home_reg} + r_sq_next;
        else
            sum_w = {1'b0, home_reg} + {1'b0, off_reg};
        dif_w = {1'b0, home_reg} + SizeW - {1'b0, off_reg};
        if (minus_reg)
            pos_next = (dif_w >= SizeW) ? dif_w - SizeW : dif_w;
        else
            pos_next = (sum_w >= SizeW) ? sum_w - SizeW : sum_w;
        // fold the high key bits back by 2^SlotBits mod size
        fold_w = (SlotBits + 1)'(key_reg[KeyBits-1:SlotBits] * FoldMul)
               + {1'b0, key_reg[SlotBits-1:0]};
        home_w = (fold_w >= SizeW) ? fold_w - SizeW : fold_w;
        odd_w = {1'b0, odd_reg} + 2'd2;
        if (odd_w >= SizeW)
            odd_w = odd_w - SizeW;
    end

    assign cnew = v_rd ? c_rd + 1'b1 : count_t'(1);
    assign changed = !v_rd || (c_rd != CountMax);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_write)
            vmem[clr_reg] <= 1'b0;
        else if (cmd.commit && changed)
        begin
            vmem[pos_reg] <= 1'b1;
            nmem[pos_reg] <= num_reg;
            cmem[pos_reg] <= cnew;
        end
        if (cmd.rd)
        begin
            v_rd <= vmem[pos_reg];
            n_rd <= nmem[pos_reg];
            c_rd <= cmem[pos_reg];
        end
        if (cmd.load)
        begin
            num_reg <= phone_bcd;
            key_reg <= KeyBits'(dig(phone_bcd, 1) * (100000 % TableSize)
                     + dig(phone_bcd, 2) * (10000 % TableSize)
                     + dig(phone_bcd, 5) * (1000 % TableSize)
                     + dig(phone_bcd, 6) * (100 % TableSize)
                     + dig(phone_bcd, 9) * (10 % TableSize)
                     + dig(phone_bcd, 10));
        end
        if (cmd.hash)
        begin
            home_reg <= home_w[SlotBits-1:0];
            pos_reg <= home_w[SlotBits-1:0];
            off_reg <= '0;
            odd_reg <= slot_t'(1);
            minus_reg <= 1'b0;
            j_reg <= '0;
        end
        else if (cmd.step)
        begin
            pos_reg <= pos_next[SlotBits-1:0];
            j_reg <= j_reg + 1'b1;
            minus_reg <= !minus_reg;
            if (!minus_reg)
            begin
                off_reg <= r_sq_next[SlotBits-1:0];
                odd_reg <= odd_w[SlotBits-1:0];
            end
        end
        if (cmd.out_load)
        begin
            o_num_reg <= best_num_reg;
            o_cnt_reg <= best_cnt_reg;
            o_ties_reg <= best_ties_reg;
            o_new_reg <= new_reg;
            o_full_reg <= full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            best_num_reg <= '0;
            best_cnt_reg <= '0;
            best_ties_reg <= '0;
            new_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_write)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.load)
            begin
                new_reg <= 1'b0;
                full_reg <= 1'b0;
            end
            if (cmd.full)
                full_reg <= 1'b1;
            if (cmd.commit && changed)
            begin
                new_reg <= !v_rd;
                if (cnew > best_cnt_reg)
                begin
                    best_cnt_reg <= cnew;
                    best_num_reg <= num_reg;
                    best_ties_reg <= tie_t'(1);
                end
                else if (cnew == best_cnt_reg)
                begin
                    if (num_reg < best_num_reg)
                        best_num_reg <= num_reg;
                    if (best_ties_reg != tie_t'(TieMax))
                        best_ties_reg <= best_ties_reg + 1'b1;
                end
            end
        end
    end

    assign leader_bcd = o_num_reg;
    assign leader_count = o_cnt_reg;
    assign tie_total = o_ties_reg;
    assign was_new = o_new_reg;
    assign table_full = o_full_reg;
endmodule
`default_nettype wire

[sv/hash_frequency_counter_top_key.sv]
// Top level of the phone-number hit counter.
// Joins hfc_ctrl and hfc_dp. Depends on hfc_pkg.
//
// After reset the block sweeps its 2039-slot valid memory, one slot a cycle,
// before taking the first item. Each item is hashed and probed until a free
// or matching slot is found, or the table is found full and the item dropped;
// no new item is taken until its result has been loaded for output. The probe
// loop reads the slot memory once per probe through a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hash_frequency_counter_top_key
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire [43:0]  phone_bcd,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [43:0] leader_bcd,
    output logic [19:0] leader_count,
    output logic [10:0] tie_total,
    output logic        was_new,
    output logic        table_full
);
    import hfc_pkg::*;

    cmd_t    cmd;
    status_t sts;

    hfc_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
    );

    hfc_dp u_dp
    (
        .clk(clk), .rst_n(rst_n), .phone_bcd(phone_bcd), .cmd(cmd), .sts(sts),
        .leader_bcd(leader_bcd), .leader_count(leader_count), .tie_total(tie_total),
        .was_new(was_new), .table_full(table_full)
    );

    a_new_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_new && table_full)) else $error("new and full together");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.load, cmd.rd, cmd.commit, cmd.out_load}) <= 1)
        else $error("overlapping commands");
    a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_new) |-> leader_count != '0) else $error("empty leader");
endmodule
`default_nettype wire

[tb/sv/hash_frequency_counter_top_key_test.sv]
// Testbench for hash_frequency_counter_top_key: drives phone numbers with random
// gaps and output stalls, predicts leader, ties and flags. Depends on hfc_pkg.
`timescale 1ns / 1ps
module hash_frequency_counter_top_key_test;
    import hfc_pkg::*;

    typedef struct {
        phone_t leader;
        count_t lead_cnt;
        tie_t   ties;
        bit     is_new;
        bit     full;
    } tally_t;

    class call_tally;
        bit       used_flag[TableSize];
        phone_t   number[TableSize];
        count_t   hits[TableSize];
        phone_t   lead;
        count_t   lead_cnt;
        int       ties;
        int       used;
        int       errors;
        tally_t   pending[$];

        function new();
            lead = '0;
            lead_cnt = '0;
            ties = 0;
            used = 0;
            errors = 0;
            foreach (used_flag[i]) used_flag[i] = 1'b0;
        endfunction

        function int home_slot(phone_t p);
            int k;
            k = p[39:36] * 100000 + p[35:32] * 10000 + p[23:20] * 1000
              + p[19:16] * 100 + p[7:4] * 10 + p[3:0];
            return k % TableSize;
        endfunction

        function void note_input(phone_t p);
            tally_t r;
            int h;
            int pos;
            int off;
            int slot;
            bit grew;
            h = home_slot(p);
            slot = -1;
            for (int j = 0; j < TableSize && slot < 0; j++) begin
                off = ((j + 1) / 2) * ((j + 1) / 2) % TableSize;
                if (j == 0)
                    pos = h;
                else if (j % 2 == 1)
                    pos = (h + off) % TableSize;
                else
                    pos = (h + TableSize - off) % TableSize;
                if (!used_flag[pos] || number[pos] == p)
                    slot = pos;
            end
            r.is_new = 1'b0;
            r.full = 1'b0;
            grew = 1'b0;
            if (slot < 0) begin
                r.full = 1'b1;
            end else if (!used_flag[slot]) begin
                used_flag[slot] = 1'b1;
                number[slot] = p;
                hits[slot] = 1;
                used++;
                r.is_new = 1'b1;
                grew = 1'b1;
            end else if (hits[slot] != '1) begin
                hits[slot]++;
                grew = 1'b1;
            end
            if (grew) begin
                if (hits[slot] > lead_cnt) begin
                    lead_cnt = hits[slot];
                    lead = p;
                    ties = 1;
                end else if (hits[slot] == lead_cnt) begin
                    if (p < lead)
                        lead = p;
                    if (ties < 2047)
                        ties++;
                end
            end
            r.leader = lead;
            r.lead_cnt = lead_cnt;
            r.ties = tie_t'(ties);
            pending = {pending, r};
        endfunction

        function void check_result(phone_t l, count_t c, tie_t t, bit n, bit f);
            tally_t e;
            if (pending.size() == 0) begin
                $error("unexpected result leader_bcd=%h", l);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (l !== e.leader) begin
                $error("leader_bcd expected %h actual %h", e.leader, l);
                errors++;
            end
            if (c !== e.lead_cnt) begin
                $error("leader_count expected %0d actual %0d", e.lead_cnt, c);
                errors++;
            end
            if (t !== e.ties) begin
                $error("tie_total expected %0d actual %0d", e.ties, t);
                errors++;
            end
            if (n !== e.is_new) begin
                $error("was_new expected %0d actual %0d", e.is_new, n);
                errors++;
            end
            if (f !== e.full) begin
                $error("table_full expected %0d actual %0d", e.full, f);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [43:0] phone_bcd;
    logic        out_valid;
    logic        out_stall;
    logic [43:0] leader_bcd;
    logic [19:0] leader_count;
    logic [10:0] tie_total;
    logic        was_new;
    logic        table_full;

    call_tally tally;
    phone_t    pool[48];
    int        sent;
    int        idle_cycles;

    hash_frequency_counter_top_key i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .phone_bcd(phone_bcd),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .leader_bcd(leader_bcd),
        .leader_count(leader_count),
        .tie_total(tie_total),
        .was_new(was_new),
        .table_full(table_full)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic phone_t random_bcd();
        phone_t p;
        for (int i = 0; i < 11; i++)
            p[i*4 +: 4] = 4'($urandom_range(0, 9));
        return p;
    endfunction

    task automatic send_number(phone_t p);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        phone_bcd <= p;
        do
            @(posedge clk);
        while (in_stall);
        tally.note_input(p);
        sent++;
    endtask

    // receiver: random stalls, one long hold-off early in the random phase
    initial
    begin
        int gap;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent >= 200)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            tally.check_result(leader_bcd, leader_count, tie_total, was_new, table_full);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 12000)
        begin
            $display("FAIL hash_frequency_counter_top_key");
            $finish;
        end
    end

    initial
    begin
        tally = new();
        sent = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        phone_bcd = '0;
        foreach (pool[i]) pool[i] = random_bcd();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_number(44'h0);
        send_number(44'hFFFFFFFFFFF);
        send_number(44'h0);
        send_number(44'h12345678901);
        send_number(44'h99999999999);
        send_number(44'h99999999999);
        send_number(44'hA0B0C0D0E0F);
        send_number(44'h05551234567);
        send_number(44'h05551234566);
        send_number(44'h05551234567);
        send_number(44'h05551234566);
        send_number(44'h01122334455);
        send_number(44'h91122334455);
        send_number(44'h51122334455);
        send_number(44'h91122334455);
        send_number(44'h0);

        repeat (1632)
        begin
            if ($urandom_range(0, 99) < 85)
                send_number(pool[$urandom_range(0, 47)]);
            else
                send_number(44'({$urandom, $urandom}));
        end
        send_number(pool[0]);
        send_number(44'hFFFFFFFFFFE);
        in_valid <= 1'b0;

        while (tally.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (tally.errors == 0 && tally.pending.size() == 0)
            $display("PASS hash_frequency_counter_top_key");
        else
            $display("FAIL hash_frequency_counter_top_key");
        $finish;
    end
endmodule

[sim.f]
sv/hfc_pkg.sv
sv/hfc_ctrl.sv
sv/hfc_dp.sv
sv/hash_frequency_counter_top_key.sv
tb/sv/hash_frequency_counter_top_key_test.sv
